@@ hdl/scwr_pkg.sv @@
// ============================================================================
// Sound chip write remapper package
// Word types, register indexes, chip register addresses and channel numbers
// shared by the write remapper.
// ============================================================================
package scwr_pkg;

  // Input word: one raw chip register write.
  typedef struct packed {
    logic [7:0] command;
    logic [7:0] reg_address;
    logic [7:0] write_data;
  } scwr_in_t;

  // Output word: the remapped write.
  typedef struct packed {
    logic [7:0] command_out;
    logic [7:0] address_out;
    logic [7:0] data_out;
    logic       dropped;
  } scwr_out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MUTE_MASK   = 2'd0,
    CFG_NODATA_MASK = 2'd1,
    CFG_CHIP_MAP    = 2'd2,
    CFG_VOICE_MAP   = 2'd3
  } scwr_cfg_e;

  // Classes of write, decided from command, address and data.
  typedef enum logic [2:0] {
    KIND_PSG_LATCH,
    KIND_PSG_DATA,
    KIND_KEY_ON,
    KIND_FM_VOICE,
    KIND_FM_FIXED
  } scwr_kind_e;

  // Widths of the configuration registers.
  localparam int unsigned NumChannels = 12;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned VoiceMapW   = 36;

  localparam logic [VoiceMapW-1:0] VoiceMapReset = 36'd2283156544;

  // Command codes.
  localparam logic [7:0] CMD_PSG     = 8'h00;
  localparam logic [7:0] CMD_DROPPED = 8'hFF;

  // FM register addresses.
  localparam logic [7:0] ADDR_KEY_ON     = 8'h28;
  localparam logic [7:0] ADDR_DAC_DATA   = 8'h2A;
  localparam logic [7:0] ADDR_DAC_ENABLE = 8'h2B;
  localparam logic [7:0] ADDR_CH3_LO     = 8'hA8;
  localparam logic [7:0] ADDR_CH3_HI     = 8'hAE;
  localparam logic [7:0] ADDR_TIMER_LO   = 8'h24;
  localparam logic [7:0] ADDR_TIMER_HI   = 8'h27;
  localparam logic [7:0] ADDR_GLOBAL_END = 8'h2F;
  localparam logic [7:0] ADDR_UPPER_GLB  = 8'hB8;

  // Logical channels.
  localparam logic [3:0] CH_FM_GLOBAL = 4'd0;
  localparam logic [3:0] CH_FM_THREE  = 4'd3;
  localparam logic [3:0] CH_DAC       = 4'd7;
  localparam logic [3:0] CH_PSG_NOISE = 4'd11;

endpackage

@@ hdl/sound_chip_write_remapper.sv @@
// ============================================================================
// Sound chip write remapper
// Classifies FM and PSG register writes by logical channel, drops writes to
// blocked channels and rewrites voice, port and target board.
// ============================================================================
//
//  Channel | Handshake                | Word
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o  | in_word_i  (command, address, data)
//  out     | out_valid_o / out_ready_i| out_word_o (command, address, data,
//          |                          |            dropped)
//  cfg     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle as long as the output takes words. A word
// passes through the input register and then the output register. Reset
// clears both valid flags, the stored PSG channel and the mask and chip map
// registers, and loads VoiceMapReset into the voice map. A stall at the output
// fills the input register and then drops in_ready_o; nothing is lost.
module sound_chip_write_remapper
  import scwr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scwr_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scwr_out_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [NumChannels-1:0]   mute_mask_q;
  logic [NumChannels-1:0]   nodata_mask_q;
  logic [4*NumChannels-1:0] chip_map_q;
  logic [VoiceMapW-1:0]     voice_map_q;
  logic [1:0]               last_psg_q;

  logic      s1_valid_q;
  scwr_in_t  s1_q;
  logic      out_valid_q;
  scwr_out_t out_q;

  logic      s1_adv;
  logic      in_acc;

  scwr_kind_e kind;
  logic [3:0] ch;
  logic       slot_bad;
  logic       drop;
  logic [3:0] board;
  logic [2:0] voice;
  logic [3:0] voice_adj;
  logic [7:0] cmd;
  logic [7:0] addr;
  logic [7:0] data;
  scwr_out_t  res;

  // Handshake: the input register moves on whenever the output can take it.
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_mask_q   <= '0;
      nodata_mask_q <= '0;
      chip_map_q    <= '0;
      voice_map_q   <= VoiceMapReset;
    end else if (cfg_we_i) begin
      case (scwr_cfg_e'(cfg_index_i))
        CFG_MUTE_MASK:   mute_mask_q   <= cfg_data_i[NumChannels-1:0];
        CFG_NODATA_MASK: nodata_mask_q <= cfg_data_i[NumChannels-1:0];
        CFG_CHIP_MAP:    chip_map_q    <= cfg_data_i[4*NumChannels-1:0];
        CFG_VOICE_MAP:   voice_map_q   <= cfg_data_i[VoiceMapW-1:0];
        default: ;
      endcase
    end
  end

  // Classify the write and pick its logical channel.
  always_comb begin
    kind     = KIND_FM_FIXED;
    ch       = CH_FM_GLOBAL;
    slot_bad = 1'b0;
    if (s1_q.command == CMD_PSG) begin
      if (s1_q.write_data[7]) begin
        kind = KIND_PSG_LATCH;
        ch   = {2'b10, s1_q.write_data[6:5]};
      end else begin
        kind = KIND_PSG_DATA;
        ch   = {2'b10, last_psg_q};
      end
    end else if (s1_q.reg_address == ADDR_KEY_ON) begin
      kind     = KIND_KEY_ON;
      slot_bad = (s1_q.write_data[1:0] == 2'b11);
      if (s1_q.write_data[2]) begin
        ch = {1'b0, s1_q.write_data[2:0]};
      end else begin
        ch = {2'b00, s1_q.write_data[1:0]} + 4'd1;
      end
    end else if (s1_q.reg_address == ADDR_DAC_DATA ||
                 s1_q.reg_address == ADDR_DAC_ENABLE) begin
      ch = CH_DAC;
    end else if (s1_q.reg_address inside {[ADDR_CH3_LO:ADDR_CH3_HI],
                                          [ADDR_TIMER_LO:ADDR_TIMER_HI]}) begin
      ch = CH_FM_THREE;
    end else if (s1_q.reg_address <= ADDR_GLOBAL_END ||
                 s1_q.reg_address >= ADDR_UPPER_GLB) begin
      ch = CH_FM_GLOBAL;
    end else begin
      // Per-voice register: slot from address, upper port adds three.
      kind     = KIND_FM_VOICE;
      slot_bad = (s1_q.reg_address[1:0] == 2'b11);
      ch       = {2'b00, s1_q.reg_address[1:0]} + 4'd1
                 + (s1_q.command[0] ? 4'd3 : 4'd0);
    end
  end

  // Table lookups for the chosen channel and the rewritten fields.
  always_comb begin
    drop      = slot_bad || mute_mask_q[ch] || nodata_mask_q[ch];
    board     = chip_map_q[4*ch +: 4];
    voice     = voice_map_q[3*ch +: 3];
    // FM voices 3 and up skip the unused slot between the two ports.
    voice_adj = {1'b0, voice} + ((voice >= 3'd3) ? 4'd1 : 4'd0);
    cmd       = s1_q.command;
    addr      = s1_q.reg_address;
    data      = s1_q.write_data;
    case (kind)
      KIND_PSG_LATCH: begin
        if (ch != CH_PSG_NOISE) begin
          data = {s1_q.write_data[7], voice[1:0], s1_q.write_data[4:0]};
        end
      end
      KIND_KEY_ON: begin
        data = {s1_q.write_data[7:4], s1_q.write_data[3] | voice_adj[3],
                voice_adj[2:0]};
      end
      KIND_FM_VOICE: begin
        addr = {s1_q.reg_address[7:2], voice_adj[1:0]};
        cmd  = {s1_q.command[7:1], voice_adj[2]};
      end
      default: ;
    endcase
    if (drop) begin
      res.command_out = CMD_DROPPED;
      res.address_out = s1_q.reg_address;
      res.data_out    = s1_q.write_data;
      res.dropped     = 1'b1;
    end else begin
      res.command_out = cmd | {board, 4'b0000};
      res.address_out = addr;
      res.data_out    = data;
      res.dropped     = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_word_i;
    end
  end

  // Stored PSG channel, updated by every latch byte, muted or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_psg_q <= 2'b00;
    end else if (s1_adv && kind == KIND_PSG_LATCH) begin
      last_psg_q <= s1_q.write_data[6:5];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // A dropped word always carries the dropped command code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.dropped |-> out_q.command_out == CMD_DROPPED)
    else $error("dropped word without dropped command code");

  // Back-pressure only arises when the input register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked output");

  // A word held in the input register stays put while it cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("input register lost or changed a waiting word");

  // A latch byte that passes through sets the stored PSG channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && kind == KIND_PSG_LATCH |=> last_psg_q == $past(s1_q.write_data[6:5]))
    else $error("stored PSG channel not updated by latch byte");

endmodule

@@ tb/sound_chip_write_remapper_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Sound chip write remapper testbench
// Drives FM and PSG register writes through the remapper under several
// register settings. Each output word is checked against a predicted remap.
// Both handshakes idle at random, and the receiver also holds off for long
// stretches so that the block fills up.
// ============================================================================
module sound_chip_write_remapper_test;
  import scwr_pkg::*;

  // Clock, reset and block ports.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  scwr_in_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  scwr_out_t           out_word;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_MUTE_MASK;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Shadow copies of the configuration and of the stored PSG channel.
  logic [NumChannels-1:0]   mute_q = '0;
  logic [NumChannels-1:0]   nodata_q = '0;
  logic [4*NumChannels-1:0] chip_q = '0;
  logic [VoiceMapW-1:0]     voice_q = VoiceMapReset;
  logic [1:0]               psg_chan = 2'd0;

  // Writes waiting to be sent, and remapped words waiting to come out.
  scwr_in_t  write_backlog[$];
  scwr_out_t remapped_q[$];

  int unsigned words_checked = 0;
  int unsigned words_dropped = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;

  sound_chip_write_remapper u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic channel_blocked(logic [3:0] ch);
    return mute_q[ch] | nodata_q[ch];
  endfunction

  function automatic logic [3:0] board_of(logic [3:0] ch);
    return chip_q[4*ch +: 4];
  endfunction

  function automatic logic [2:0] voice_of(logic [3:0] ch);
    return voice_q[3*ch +: 3];
  endfunction

  // Predicts the remapped word for one accepted write and advances the stored
  // PSG channel. A latch byte updates it even when its channel is blocked.
  function automatic scwr_out_t remap_write(scwr_in_t w);
    logic [7:0] cmd;
    logic [7:0] addr;
    logic [7:0] data;
    logic [3:0] ch;
    logic [2:0] vraw;
    logic [3:0] vfm;
    logic       bad_slot;
    scwr_kind_e kind;
    scwr_out_t  res;
    cmd = w.command;
    addr = w.reg_address;
    data = w.write_data;
    bad_slot = 1'b0;
    kind = KIND_FM_FIXED;
    if (cmd == CMD_PSG) begin
      if (data[7]) begin
        kind = KIND_PSG_LATCH;
        psg_chan = data[6:5];
      end else begin
        kind = KIND_PSG_DATA;
      end
      ch = {2'b10, psg_chan};
    end else if (addr == ADDR_KEY_ON) begin
      // Slot 3 and 7 are not channels; slots 0-2 are voices 1-3.
      kind = KIND_KEY_ON;
      bad_slot = (data[1:0] == 2'b11);
      ch = data[2] ? {1'b0, data[2:0]} : {2'b00, data[1:0]} + 4'd1;
    end else if (addr == ADDR_DAC_DATA || addr == ADDR_DAC_ENABLE) begin
      ch = CH_DAC;
    end else if ((addr >= ADDR_CH3_LO && addr <= ADDR_CH3_HI) ||
                 (addr >= ADDR_TIMER_LO && addr <= ADDR_TIMER_HI)) begin
      ch = CH_FM_THREE;
    end else if (addr <= ADDR_GLOBAL_END || addr >= ADDR_UPPER_GLB) begin
      ch = CH_FM_GLOBAL;
    end else begin
      kind = KIND_FM_VOICE;
      bad_slot = (addr[1:0] == 2'b11);
      ch = {2'b00, addr[1:0]} + (cmd[0] ? 4'd4 : 4'd1);
    end

    if (bad_slot || channel_blocked(ch)) begin
      res = '{command_out: CMD_DROPPED, address_out: w.reg_address,
              data_out: w.write_data, dropped: 1'b1};
    end else begin
      // FM voices skip slot 3, so voices 3 and up move one place on.
      vraw = voice_of(ch);
      vfm = (vraw >= 3'd3) ? {1'b0, vraw} + 4'd1 : {1'b0, vraw};
      case (kind)
        KIND_PSG_LATCH: begin
          if (ch != CH_PSG_NOISE) data[6:5] = vraw[1:0];
        end
        KIND_KEY_ON: begin
          data = {data[7:3], 3'b000} | {4'b0000, vfm};
        end
        KIND_FM_VOICE: begin
          addr[1:0] = vfm[1:0];
          cmd[0] = vfm[2];
        end
        default: ;
      endcase
      res = '{command_out: cmd | {board_of(ch), 4'b0000}, address_out: addr,
              data_out: data, dropped: 1'b0};
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic scwr_in_t mk_write(logic [7:0] cmd, logic [7:0] addr, logic [7:0] data);
    return '{command: cmd, reg_address: addr, write_data: data};
  endfunction

  // FM commands are mostly port selects, sometimes with high bits set.
  function automatic logic [7:0] fm_command();
    if ($urandom_range(9, 0) < 7) return 8'($urandom_range(3, 1));
    return 8'($urandom_range(255, 1));
  endfunction

  // A random write, weighted towards each class of register.
  function automatic scwr_in_t random_write();
    int unsigned r;
    logic [7:0]  addr;
    r = $urandom_range(99, 0);
    if (r < 15) return mk_write(CMD_PSG, 8'($urandom), {1'b1, 7'($urandom)});
    if (r < 27) return mk_write(CMD_PSG, 8'($urandom), {1'b0, 7'($urandom)});
    if (r < 40) return mk_write(fm_command(), ADDR_KEY_ON, 8'($urandom));
    if (r < 46) begin
      addr = $urandom_range(1, 0) ? ADDR_DAC_DATA : ADDR_DAC_ENABLE;
      return mk_write(fm_command(), addr, 8'($urandom));
    end
    if (r < 54) begin
      addr = $urandom_range(1, 0) ? 8'($urandom_range(ADDR_CH3_HI, ADDR_CH3_LO))
                                  : 8'($urandom_range(ADDR_TIMER_HI, ADDR_TIMER_LO));
      return mk_write(fm_command(), addr, 8'($urandom));
    end
    if (r < 62) begin
      addr = $urandom_range(1, 0) ? 8'($urandom_range(ADDR_GLOBAL_END, 0))
                                  : 8'($urandom_range(255, ADDR_UPPER_GLB));
      return mk_write(fm_command(), addr, 8'($urandom));
    end
    if (r < 88) return mk_write(fm_command(), 8'($urandom_range(8'hB7, 8'h30)), 8'($urandom));
    return mk_write(8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Sender: offers the backlog one word at a time, with random gaps and
  // occasional stretches without gaps.
  always @(posedge clk) begin : write_driver
    int unsigned tx_gap;
    int unsigned tx_calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      tx_calm = 0;
    end else begin
      if (in_valid && in_ready) remapped_q.push_back(remap_write(in_word));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (write_backlog.size() > 0) begin
          in_word <= write_backlog.pop_front();
          in_valid <= 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = pick_gap();
            if ($urandom_range(63, 0) == 0) tx_calm = $urandom_range(60, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output word against the oldest prediction and
  // stalls at random, with a long hold-off now and then.
  always @(posedge clk) begin : result_monitor
    scwr_out_t   want;
    int unsigned rx_stall;
    int unsigned rx_calm;
    int unsigned rx_hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
      rx_calm = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (remapped_q.size() == 0) begin
          $error("output word %h arrived with no write outstanding", out_word);
          mismatches++;
        end else begin
          want = remapped_q.pop_front();
          if (out_word.command_out !== want.command_out) begin
            $error("command_out: expected %02h, got %02h", want.command_out,
                   out_word.command_out);
            mismatches++;
          end
          if (out_word.address_out !== want.address_out) begin
            $error("address_out: expected %02h, got %02h", want.address_out,
                   out_word.address_out);
            mismatches++;
          end
          if (out_word.data_out !== want.data_out) begin
            $error("data_out: expected %02h, got %02h", want.data_out, out_word.data_out);
            mismatches++;
          end
          if (out_word.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, out_word.dropped);
            mismatches++;
          end
          words_checked++;
          if (want.dropped) words_dropped++;
          // Hold off for a long time so that the block backs up.
          if (words_checked % 700 == 150) rx_hold = 80;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = pick_gap();
          if ($urandom_range(63, 0) == 0) rx_calm = $urandom_range(60, 20);
        end
      end
    end
  end

  // Writes one register and updates the shadow copy.
  task automatic write_cfg(input scwr_cfg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MUTE_MASK:   mute_q = val[NumChannels-1:0];
      CFG_NODATA_MASK: nodata_q = val[NumChannels-1:0];
      CFG_CHIP_MAP:    chip_q = val[4*NumChannels-1:0];
      CFG_VOICE_MAP:   voice_q = val[VoiceMapW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] mute,
                                input logic [CfgDataW-1:0] nodata,
                                input logic [CfgDataW-1:0] chips,
                                input logic [CfgDataW-1:0] voices);
    write_cfg(CFG_MUTE_MASK, mute);
    write_cfg(CFG_NODATA_MASK, nodata);
    write_cfg(CFG_CHIP_MAP, chips);
    write_cfg(CFG_VOICE_MAP, voices);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Waits until every queued write has gone through and been checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (write_backlog.size() != 0 || in_valid || remapped_q.size() != 0);
  endtask

  // Queues random writes; a PSG latch is often followed by data bytes.
  task automatic queue_random(input int unsigned count);
    int unsigned queued;
    scwr_in_t    w;
    queued = 0;
    while (queued < count) begin
      w = random_write();
      write_backlog.push_back(w);
      queued++;
      if (w.command == CMD_PSG && w.write_data[7]) begin
        repeat ($urandom_range(2, 0)) begin
          write_backlog.push_back(mk_write(CMD_PSG, 8'($urandom), {1'b0, 7'($urandom)}));
          queued++;
        end
      end
    end
    wait_drained();
  endtask

  // Run limit.
  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed writes under the reset settings.
    write_backlog.push_back(mk_write(CMD_PSG, 8'hFF, 8'h80));
    write_backlog.push_back(mk_write(CMD_PSG, 8'h00, 8'hBF));
    write_backlog.push_back(mk_write(CMD_PSG, 8'h00, 8'hDF));
    write_backlog.push_back(mk_write(CMD_PSG, 8'h00, 8'hFF));
    write_backlog.push_back(mk_write(CMD_PSG, 8'hFF, 8'h00));
    write_backlog.push_back(mk_write(CMD_PSG, 8'h00, 8'h7F));
    write_backlog.push_back(mk_write(8'h01, ADDR_KEY_ON, 8'h00));
    write_backlog.push_back(mk_write(8'h01, ADDR_KEY_ON, 8'h02));
    write_backlog.push_back(mk_write(8'h01, ADDR_KEY_ON, 8'h03));
    write_backlog.push_back(mk_write(8'h02, ADDR_KEY_ON, 8'h04));
    write_backlog.push_back(mk_write(8'h01, ADDR_KEY_ON, 8'hF6));
    write_backlog.push_back(mk_write(8'h01, ADDR_KEY_ON, 8'h07));
    write_backlog.push_back(mk_write(8'h01, ADDR_DAC_DATA, 8'hFF));
    write_backlog.push_back(mk_write(8'h01, ADDR_DAC_ENABLE, 8'h80));
    write_backlog.push_back(mk_write(8'h01, ADDR_TIMER_LO, 8'h12));
    write_backlog.push_back(mk_write(8'h01, ADDR_TIMER_HI, 8'h40));
    write_backlog.push_back(mk_write(8'h02, ADDR_CH3_LO, 8'h55));
    write_backlog.push_back(mk_write(8'h02, ADDR_CH3_HI, 8'hAA));
    write_backlog.push_back(mk_write(8'h01, 8'h00, 8'h00));
    write_backlog.push_back(mk_write(8'h01, ADDR_GLOBAL_END, 8'hFF));
    write_backlog.push_back(mk_write(8'h02, ADDR_UPPER_GLB, 8'h3C));
    write_backlog.push_back(mk_write(8'hFF, 8'hFF, 8'hFF));
    write_backlog.push_back(mk_write(8'h01, 8'h30, 8'h1F));
    write_backlog.push_back(mk_write(8'h01, 8'h33, 8'h00));
    write_backlog.push_back(mk_write(8'hFF, 8'hB6, 8'h00));
    write_backlog.push_back(mk_write(8'hF0, 8'hA2, 8'hC3));
    wait_drained();

    // Extreme maps: every board 15 and every voice 7.
    apply_settings('0, '0, 48'hFFFF_FFFF_FFFF, 48'h0000_000F_FFFF_FFFF);
    queue_random(240);
    // All maps cleared.
    apply_settings('0, '0, '0, '0);
    queue_random(200);
    // Every channel muted, then every channel without data.
    apply_settings(48'hFFF, '0, 48'($urandom), 48'($urandom));
    queue_random(80);
    apply_settings('0, 48'hFFF, 48'($urandom), 48'($urandom));
    queue_random(80);
    // Random settings with sparse masks.
    repeat (5) begin
      apply_settings(48'($urandom & $urandom & 12'hFFF),
                     48'($urandom & $urandom & $urandom & 12'hFFF),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      queue_random(240);
    end

    // Let any stray output word show up.
    repeat (6) @(posedge clk);
    $display("Remapped %0d writes (%0d dropped, %0d kept) under %0d register settings.",
             words_checked, words_dropped, words_checked - words_dropped, settings_used + 1);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
